### design/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/mlcb_pkg.sv
// ----------------------------------------------------------------------------
// mlcb_pkg
// Types, constants and tables shared by the camera basis block.
// ----------------------------------------------------------------------------
package mlcb_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int IterW = $clog2(TRIG_ITERATIONS + 1);

    localparam logic signed [15:0] PitchLim = 16'sd11392;
    localparam logic signed [17:0] HalfTurn = 18'sd23040;
    localparam logic signed [17:0] FullTurn = 18'sd46080;
    localparam logic signed [17:0] QuarterTurn = 18'sd11520;
    localparam logic signed [15:0] ZoomMin = 16'sd256;
    localparam logic signed [15:0] ZoomMax = 16'sd11520;
    localparam logic signed [15:0] ZoomReset = 16'sd11520;
    localparam logic [15:0] SensReset = 16'd6554;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Ninety-two whole turns lift any yaw sum above zero before the turn count.
    localparam logic signed [33:0] YawBias = 34'sd4239360;
    // Rounded-up 2^18 / 45, exact for quotients of sums below 2^23 by 1024.
    localparam logic [12:0] FullTurnRecip = 13'd5826;

    typedef struct packed {
        logic signed [15:0] look_dx;
        logic signed [15:0] look_dy;
        logic signed [15:0] zoom_delta;
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [31:0] player_z;
        logic toggle_mode;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [47:0] front_vec;
        logic [47:0] right_vec;
        logic [47:0] up_vec;
        logic signed [15:0] zoom_level;
        logic view_third;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic signed [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cordic_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_STEP, ST_ANGLE, ST_YAW_GO, ST_YAW_WAIT, ST_PITCH_GO,
        ST_PITCH_WAIT, ST_MUL_A, ST_MUL_B, ST_FINISH, ST_OUT
    } seq_state_t;

    function automatic logic [23:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0: atan_deg = 24'd2949120;
            5'd1: atan_deg = 24'd1740967;
            5'd2: atan_deg = 24'd919879;
            5'd3: atan_deg = 24'd466945;
            5'd4: atan_deg = 24'd234379;
            5'd5: atan_deg = 24'd117304;
            5'd6: atan_deg = 24'd58666;
            5'd7: atan_deg = 24'd29335;
            5'd8: atan_deg = 24'd14668;
            5'd9: atan_deg = 24'd7334;
            5'd10: atan_deg = 24'd3667;
            5'd11: atan_deg = 24'd1833;
            5'd12: atan_deg = 24'd917;
            5'd13: atan_deg = 24'd458;
            5'd14: atan_deg = 24'd229;
            5'd15: atan_deg = 24'd115;
            5'd16: atan_deg = 24'd57;
            5'd17: atan_deg = 24'd29;
            5'd18: atan_deg = 24'd14;
            5'd19: atan_deg = 24'd7;
            5'd20: atan_deg = 24'd4;
            5'd21: atan_deg = 24'd2;
            5'd22: atan_deg = 24'd1;
            default: atan_deg = 24'd0;
        endcase
    endfunction

    function automatic logic signed [15:0] q30_to_q14(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] s;
        t = 35'(v) + 35'sd32768;
        s = 19'(t >>> 16);
        if (s > 19'sd16384) q30_to_q14 = 16'sd16384;
        else if (s < -19'sd16384) q30_to_q14 = -16'sd16384;
        else q30_to_q14 = 16'(s);
    endfunction

    function automatic logic signed [15:0] q60_to_q14(input logic signed [67:0] v);
        logic signed [68:0] t;
        logic signed [22:0] s;
        t = 69'(v) + (69'sd1 <<< 45);
        s = 23'(t >>> 46);
        if (s > 23'sd16384) q60_to_q14 = 16'sd16384;
        else if (s < -23'sd16384) q60_to_q14 = -16'sd16384;
        else q60_to_q14 = 16'(s);
    endfunction

endpackage

### design/mlcb_cordic.sv
// ----------------------------------------------------------------------------
// mlcb_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of a Q8.7 angle.
// ----------------------------------------------------------------------------
module mlcb_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mlcb_pkg::cordic_req_t req,
    output mlcb_pkg::cordic_rsp_t rsp
);
    import mlcb_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic [IterW-1:0] iter_reg, iter_next;
    logic busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic signed [17:0] ang;
    logic signed [33:0] xs, ys;
    logic signed [25:0] at;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        ang = 18'(req.angle);
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = 26'(atan_deg(5'(iter_reg)));
        if (req.start) begin
            neg_next = 1'b0;
            if (ang > QuarterTurn) begin
                ang = ang - HalfTurn;
                neg_next = 1'b1;
            end else if (ang < -QuarterTurn) begin
                ang = ang + HalfTurn;
                neg_next = 1'b1;
            end
            z_next = 26'(ang) <<< 9;
            x_next = CordicGain;
            y_next = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == IterW'(TRIG_ITERATIONS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        iter_reg <= iter_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.cos_v = neg_reg ? -x_reg : x_reg;
    assign rsp.sin_v = neg_reg ? -y_reg : y_reg;
endmodule

### design/mouse_look_camera_basis_top.sv
// From acceptance to the result being offered, a word passes through the
// step and angle states, the shared CORDIC run once for yaw and once for
// pitch, the basis products and the finish state. One word is in flight at
// a time, so a new word is accepted only after the last result is taken.
// Reset is synchronous, active low: angles zero, first person, zoom
// 90 degrees, sensitivity 6554.
// ----------------------------------------------------------------------------
// mouse_look_camera_basis_top
// Mouse-look camera: angle update, trig by shared CORDIC, basis and position.
// ----------------------------------------------------------------------------
module mouse_look_camera_basis_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlcb_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mlcb_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import mlcb_pkg::*;

    seq_state_t state_reg, state_next;
    in_word_t in_reg, in_next;
    out_word_t out_reg, out_next;
    logic [15:0] sens_reg;
    logic signed [15:0] fp_yaw_reg, fp_pitch_reg, tp_yaw_reg, tp_pitch_reg;
    logic signed [15:0] zoom_reg, zoom_next;
    logic mode_reg, mode_next;
    logic signed [33:0] dy_reg, dp_reg, dy_next, dp_next;
    logic signed [15:0] yaw_reg, pitch_reg, yaw_next, pitch_next;
    logic signed [33:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [67:0] pa_reg, pa_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic signed [15:0] f_reg [2];
    logic signed [15:0] u_reg [2];
    logic ang_we;
    cordic_req_t creq;
    cordic_rsp_t crsp;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [32:0] sd_x, sd_y;
    logic signed [33:0] wr, wb;
    logic [13:0] wa;
    logic [26:0] wq_prod;
    logic [7:0] wq;
    logic signed [16:0] zs;

    mlcb_cordic u_cordic (.aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data = out_reg;
    assign mul_p = mul_a * mul_b;

    function automatic logic signed [31:0] cam_pos(input logic signed [31:0] p,
            input logic signed [15:0] f, input logic tp);
        logic signed [40:0] c;
        c = 41'(p) - (41'(f) * 41'sd120);
        if (!tp) cam_pos = p;
        else if (c > 41'sd2147483647) cam_pos = 32'sh7fffffff;
        else if (c < -41'sd2147483648) cam_pos = 32'sh80000000;
        else cam_pos = 32'(c);
    endfunction

    always_comb begin
        state_next = state_reg;
        in_next = in_reg;
        out_next = out_reg;
        mode_next = mode_reg;
        zoom_next = zoom_reg;
        dy_next = dy_reg;
        dp_next = dp_reg;
        yaw_next = yaw_reg;
        pitch_next = pitch_reg;
        pa_next = pa_reg;
        mcnt_next = mcnt_reg;
        ang_we = 1'b0;
        creq.start = 1'b0;
        creq.angle = yaw_reg;
        mul_a = cy_reg;
        mul_b = cp_reg;
        sd_x = 33'(in_reg.look_dx) * $signed({17'd0, sens_reg});
        sd_y = 33'(in_reg.look_dy) * $signed({17'd0, sens_reg});
        wr = '0;
        wb = '0;
        wa = '0;
        wq_prod = '0;
        wq = '0;
        zs = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    mode_next = mode_reg ^ s_data.toggle_mode;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                dy_next = (34'(sd_x) + 34'sd256) >>> 9;
                dp_next = (34'(sd_y) + 34'sd256) >>> 9;
                state_next = ST_ANGLE;
            end
            ST_ANGLE: begin
                // The biased sum is positive, and the turn count is the sum over
                // 1024 divided by 45 through a reciprocal multiply.
                wb = 34'(mode_reg ? tp_yaw_reg : fp_yaw_reg) + dy_reg + 34'(HalfTurn)
                     + YawBias;
                wa = 14'(wb >>> 10);
                wq_prod = 27'(wa) * 27'(FullTurnRecip);
                wq = 8'(wq_prod >> 18);
                wr = wb - 34'(wq) * 34'(FullTurn);
                yaw_next = 16'(wr - 34'(HalfTurn));
                wr = 34'(mode_reg ? tp_pitch_reg : fp_pitch_reg) + dp_reg;
                if (wr > 34'(PitchLim)) pitch_next = PitchLim;
                else if (wr < -34'(PitchLim)) pitch_next = -PitchLim;
                else pitch_next = 16'(wr);
                ang_we = 1'b1;
                state_next = ST_YAW_GO;
            end
            ST_YAW_GO: begin
                creq.start = 1'b1;
                creq.angle = yaw_reg;
                state_next = ST_YAW_WAIT;
            end
            ST_YAW_WAIT: begin
                if (crsp.done) state_next = ST_PITCH_GO;
            end
            ST_PITCH_GO: begin
                creq.start = 1'b1;
                creq.angle = pitch_reg;
                state_next = ST_PITCH_WAIT;
            end
            ST_PITCH_WAIT: begin
                if (crsp.done) begin
                    mcnt_next = '0;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                case (mcnt_reg)
                    2'd0: begin mul_a = cy_reg; mul_b = cp_reg; end
                    2'd1: begin mul_a = sy_reg; mul_b = cp_reg; end
                    2'd2: begin mul_a = cy_reg; mul_b = sp_reg; end
                    default: begin mul_a = sy_reg; mul_b = sp_reg; end
                endcase
                pa_next = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                mcnt_next = mcnt_reg + 1'b1;
                state_next = (mcnt_reg == 2'd3) ? ST_FINISH : ST_MUL_A;
            end
            ST_FINISH: begin
                out_next.front_vec = {f_reg[1], q30_to_q14(sp_reg), f_reg[0]};
                out_next.right_vec = {q30_to_q14(cy_reg), 16'd0, -q30_to_q14(sy_reg)};
                out_next.up_vec = {u_reg[1], q30_to_q14(cp_reg), u_reg[0]};
                out_next.cam_x = cam_pos(in_reg.player_x, f_reg[0], mode_reg);
                out_next.cam_y = cam_pos(in_reg.player_y, q30_to_q14(sp_reg), mode_reg);
                out_next.cam_z = cam_pos(in_reg.player_z, f_reg[1], mode_reg);
                if (zoom_reg >= ZoomMin && zoom_reg <= ZoomMax) begin
                    zs = 17'(zoom_reg) - 17'(in_reg.zoom_delta);
                    if (zs > 17'sd32767) zoom_next = 16'sh7fff;
                    else if (zs < -17'sd32768) zoom_next = 16'sh8000;
                    else zoom_next = 16'(zs);
                end else if (zoom_reg < ZoomMin) zoom_next = ZoomMin;
                else zoom_next = ZoomMax;
                out_next.zoom_level = zoom_next;
                out_next.view_third = mode_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sens_reg <= SensReset;
            fp_yaw_reg <= '0;
            fp_pitch_reg <= '0;
            tp_yaw_reg <= '0;
            tp_pitch_reg <= '0;
            mode_reg <= 1'b0;
            zoom_reg <= ZoomReset;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            zoom_reg <= zoom_next;
            if (cfg_valid && cfg_ready) sens_reg <= cfg_data;
            if (ang_we && mode_reg) begin
                tp_yaw_reg <= yaw_next;
                tp_pitch_reg <= pitch_next;
            end else if (ang_we) begin
                fp_yaw_reg <= yaw_next;
                fp_pitch_reg <= pitch_next;
            end
        end
        in_reg <= in_next;
        out_reg <= out_next;
        dy_reg <= dy_next;
        dp_reg <= dp_next;
        yaw_reg <= yaw_next;
        pitch_reg <= pitch_next;
        pa_reg <= pa_next;
        mcnt_reg <= mcnt_next;
        if (state_reg == ST_YAW_WAIT && crsp.done) begin
            cy_reg <= crsp.cos_v;
            sy_reg <= crsp.sin_v;
        end
        if (state_reg == ST_PITCH_WAIT && crsp.done) begin
            cp_reg <= crsp.cos_v;
            sp_reg <= crsp.sin_v;
        end
        if (state_reg == ST_MUL_B) begin
            case (mcnt_reg)
                2'd0: f_reg[0] <= q60_to_q14(pa_reg);
                2'd1: f_reg[1] <= q60_to_q14(pa_reg);
                2'd2: u_reg[0] <= q60_to_q14(-pa_reg);
                default: u_reg[1] <= q60_to_q14(-pa_reg);
            endcase
        end
    end
endmodule

### design/mlcb_checker.sv
// ----------------------------------------------------------------------------
// mlcb_port_checker
// Port-level checks on the camera basis block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mlcb_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                cfg_ready,
    input mlcb_pkg::out_word_t m_data
);
    logic out_stall;
    logic in_take;

    assign out_stall = m_valid && !m_ready;
    assign in_take = s_valid && s_ready;

    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, m_valid |-> !s_ready, "input open")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, out_stall |=> m_valid && $stable(m_data), "word lost")
    `ASSERT_CLK(a_accept_busy, aclk, aresetn, in_take |=> !s_ready, "second word taken")
    `ASSERT_CLK(a_cfg_idle, aclk, aresetn, cfg_ready |-> !m_valid, "config while busy")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result after reset")
endmodule

bind mouse_look_camera_basis_top mlcb_port_checker u_mlcb_port_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .cfg_ready(cfg_ready), .m_data(m_data)
);
